// ===== rtl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table: opcodes, result status
// codes, string widths and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  // default number of table entries
  localparam int KVT_CAPACITY = 64;

  // string geometry: 19 bytes split into lo, mid and hi words
  localparam int STR_BYTES = 19;
  localparam int STR_W     = 8 * STR_BYTES;
  localparam int WORD_W    = 64;
  localparam int HI_W      = 24;

  // result field widths
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // stream payload widths
  localparam int IN_DATA_W  = 2 * STR_W;
  localparam int OUT_DATA_W = 168;
  localparam int OUT_USER_W = STATUS_W + 1;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // source of a table write
  typedef enum logic [1:0] {
    WR_UPDATE = 2'd0,
    WR_APPEND = 2'd1,
    WR_SHIFT  = 2'd2
  } wr_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRD,
    S_SCMP,
    S_APPEND,
    S_SHRD,
    S_SHWR,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    idx_inc;
    logic    rd_next;
    logic    ram_we;
    wr_sel_t wr_sel;
    logic    capture;
    logic    pos_append;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    load_result;
    status_t res_status;
    logic    res_found;
  } kvt_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic match;
    logic idx_last;
    logic count_zero;
    logic full;
  } kvt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/kvt_ram.sv =====
// ----------------------------------------------------------------------------
// kvt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/kvt_dp.sv =====
// ----------------------------------------------------------------------------
// kvt_dp
// Datapath of the key/value table: item registers, string canonicalization,
// the entry store, the scan index, the entry count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_dp
  import kvt_pkg::*;
#(
  parameter int CAPACITY = KVT_CAPACITY
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire kvt_cmd_t              cmd,
  output kvt_sts_t                   sts,
  input  wire logic [1:0]            in_op,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  output logic      [OUT_DATA_W-1:0] out_data,
  output logic      [OUT_USER_W-1:0] out_user
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PAD_W = OUT_DATA_W - POS_W - STR_W - COUNT_W;

  // clear every byte after the first zero byte
  function automatic logic [STR_W-1:0] canon(input logic [STR_W-1:0] s);
    logic [STR_BYTES-1:0] nz;
    logic [STR_BYTES-1:0] lowmask;
    logic [STR_W-1:0]     r;
    for (int i = 0; i < STR_BYTES; i++) begin
      nz[i] = |s[8*i +: 8];
    end
    for (int i = 0; i < STR_BYTES; i++) begin
      lowmask = (STR_BYTES'(1) << (i + 1)) - STR_BYTES'(1);
      r[8*i +: 8] = (&(nz | ~lowmask)) ? s[8*i +: 8] : 8'd0;
    end
    return r;
  endfunction

  op_t              op;
  logic [STR_W-1:0] key;
  logic [STR_W-1:0] val;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    pos;
  logic [STR_W-1:0] found_val;
  logic [CW-1:0]    count;

  logic [2*STR_W-1:0] ram_rdata;
  logic [2*STR_W-1:0] ram_wdata;
  logic [IW-1:0]      ram_waddr;
  logic [IW-1:0]      ram_raddr;

  logic [IW+POS_W-1:0]   pos_ext;
  logic [CW+COUNT_W-1:0] count_ext;
  logic [CW-1:0]         idx_ext;

  // item registers, scan index, match position and looked-up value
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op        <= op_t'(in_op);
      key       <= canon(in_data[STR_W-1:0]);
      val       <= canon(in_data[2*STR_W-1:STR_W]);
      idx       <= '0;
      pos       <= '0;
      found_val <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.capture) begin
        pos <= idx;
        if (op == OP_LOOKUP) begin
          found_val <= ram_rdata[2*STR_W-1:STR_W];
        end
      end
      if (cmd.pos_append) begin
        pos <= count[IW-1:0];
      end
    end
  end

  // entries in use
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // store write data and addresses
  always_comb begin
    case (cmd.wr_sel)
      WR_SHIFT: begin
        ram_wdata = ram_rdata;
        ram_waddr = idx;
      end
      WR_APPEND: begin
        ram_wdata = {val, key};
        ram_waddr = count[IW-1:0];
      end
      default: begin
        ram_wdata = {val, key};
        ram_waddr = idx;
      end
    endcase
    ram_raddr = cmd.rd_next ? idx + IW'(1) : idx;
  end

  // entry store: value in the upper half, key in the lower half
  kvt_ram #(
    .WIDTH (2 * STR_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status toward the controller
  always_comb begin
    idx_ext        = CW'(idx);
    sts.op         = op;
    sts.match      = (ram_rdata[STR_W-1:0] == key);
    sts.idx_last   = (idx_ext + CW'(1)) >= count;
    sts.count_zero = (count == '0);
    sts.full       = (count >= CW'(CAPACITY));
  end

  assign pos_ext   = {{POS_W{1'b0}}, pos};
  assign count_ext = {{COUNT_W{1'b0}}, count};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_data <= {{PAD_W{1'b0}}, count_ext[COUNT_W-1:0], found_val, pos_ext[POS_W-1:0]};
      out_user <= {cmd.res_found, cmd.res_status};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvt_ctrl
// Controller of the key/value table: sequences the scan, update, append and
// compaction steps and owns both stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ctrl
  import kvt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output kvt_cmd_t      cmd,
  input  wire kvt_sts_t sts
);

  state_t  state, state_next;
  logic    out_valid_next;
  status_t res_status, res_status_next;
  logic    res_found, res_found_next;

  // state and result flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      res_status <= ST_DONE;
      res_found  <= 1'b0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      res_status <= res_status_next;
      res_found  <= res_found_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_found_next  = res_found;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.wr_sel      = WR_UPDATE;
    cmd.res_status  = res_status;
    cmd.res_found   = res_found;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept      = 1'b1;
          res_status_next = ST_DONE;
          res_found_next  = 1'b0;
          state_next      = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op) inside
          OP_SET: begin
            if (sts.full) begin
              res_status_next = ST_FULL;
              state_next      = S_FINISH;
            end else if (sts.count_zero) begin
              state_next = S_APPEND;
            end else begin
              state_next = S_SRD;
            end
          end
          OP_REMOVE, OP_LOOKUP: begin
            if (sts.count_zero) begin
              res_status_next = ST_NOT_FOUND;
              state_next      = S_FINISH;
            end else begin
              state_next = S_SRD;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SRD: begin
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (sts.match) begin
          res_found_next = 1'b1;
          cmd.capture    = 1'b1;
          unique case (sts.op) inside
            OP_SET: begin
              cmd.ram_we = 1'b1;
              cmd.wr_sel = WR_UPDATE;
              state_next = S_FINISH;
            end
            OP_REMOVE: begin
              state_next = S_SHRD;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end else if (sts.idx_last) begin
          if (sts.op == OP_SET) begin
            state_next = S_APPEND;
          end else begin
            res_status_next = ST_NOT_FOUND;
            state_next      = S_FINISH;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRD;
        end
      end
      S_APPEND: begin
        cmd.ram_we     = 1'b1;
        cmd.wr_sel     = WR_APPEND;
        cmd.pos_append = 1'b1;
        cmd.cnt_inc    = 1'b1;
        state_next     = S_FINISH;
      end
      S_SHRD: begin
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.ram_we  = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_inc = 1'b1;
        state_next  = S_SHRD;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/key_value_table.sv =====
// Key/value table of up to CAPACITY entries, kept compact and unsorted.
// Each entry compared passes through a read state and a compare state (S_SRD, S_SCMP);
// a remove then shifts later entries down (S_SHRD, S_SHWR); a full set or unused op
// goes straight to S_FINISH. The next item is taken while a result waits, and a
// finished result is held until the output register is free.
// Reset clears the entry count only; entries past the count are never read.
// ----------------------------------------------------------------------------
// key_value_table
// Top level: stream ports, controller and datapath of the key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table
  import kvt_pkg::*;
#(
  parameter int CAPACITY = KVT_CAPACITY
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // key_lo, key_mid, key_hi, value_in_lo, value_in_mid, value_in_hi
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // position, value_out_lo, value_out_mid, value_out_hi, count, zero pad
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // status, found
  output logic      [OUT_USER_W-1:0] m_axis_tuser
);

  kvt_cmd_t cmd;
  kvt_sts_t sts;

  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  kvt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

  // no append into a full table
  a_no_grow_when_full: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cnt_inc && sts.full))
    else $error("entry count grown past capacity");

  // the store is never written while waiting for an item
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && cmd.ram_we))
    else $error("store written while idle");

  // a loaded result is presented on the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> m_axis_tvalid)
    else $error("loaded result not presented");

  // a matched key always reports done
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[STATUS_W] |-> m_axis_tuser[STATUS_W-1:0] == ST_DONE)
    else $error("found result with failing status");

endmodule

`default_nettype wire

// ===== tb/sv/kv_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_table_checker
// Watches both stream channels of the key/value table. Every input item that
// is taken is run through a local copy of the table, and the expected
// response is queued. Every result that leaves the block is compared field
// by field with the oldest queued response. The mismatch count and the
// number of responses still owed are handed to the testbench top.
// ----------------------------------------------------------------------------

module kv_table_checker
  import kvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // key_lo, key_mid, key_hi, value_in_lo, value_in_mid, value_in_hi
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // position, value_out_lo, value_out_mid, value_out_hi, count, zero pad
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status, found
  input  logic [OUT_USER_W-1:0] m_axis_tuser,
  output int                    mismatches,
  output int                    responses_owed
);

  typedef struct {
    status_t              status;
    logic                 found;
    logic [POS_W-1:0]     position;
    logic [STR_W-1:0]     value;
    logic [COUNT_W-1:0]   count;
  } kv_response_t;

  // local copy of the table
  logic [STR_W-1:0] entry_keys [KVT_CAPACITY];
  logic [STR_W-1:0] entry_vals [KVT_CAPACITY];
  int               entries_used = 0;

  kv_response_t     owed_q [$];
  kv_response_t     want;
  int               bad = 0;

  // zero every byte after the first zero byte
  function automatic logic [STR_W-1:0] clip_str(logic [STR_W-1:0] s);
    bit ended;
    ended = 1'b0;
    for (int i = 0; i < STR_BYTES; i++) begin
      if (ended) begin
        s[i*8 +: 8] = 8'h00;
      end else if (s[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return s;
  endfunction

  // search bounded to the entries in use
  function automatic int locate(logic [STR_W-1:0] k);
    for (int i = 0; i < entries_used; i++) begin
      if (entry_keys[i] == k) begin
        return i;
      end
    end
    return -1;
  endfunction

  // update the local table and build the response of one item
  function automatic kv_response_t apply_item(op_t op, logic [IN_DATA_W-1:0] data);
    kv_response_t     r;
    logic [STR_W-1:0] k;
    logic [STR_W-1:0] v;
    int               at;
    r.status   = ST_DONE;
    r.found    = 1'b0;
    r.position = '0;
    r.value    = '0;
    k = clip_str(data[STR_W-1:0]);
    v = clip_str(data[IN_DATA_W-1:STR_W]);
    case (op)
      OP_SET: begin
        if (entries_used >= KVT_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          at = locate(k);
          if (at >= 0) begin
            entry_vals[at] = v;
            r.found    = 1'b1;
            r.position = POS_W'(at);
          end else begin
            entry_keys[entries_used] = k;
            entry_vals[entries_used] = v;
            r.position = POS_W'(entries_used);
            entries_used++;
          end
        end
      end
      OP_REMOVE: begin
        at = locate(k);
        if (at < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // close the gap left by the removed entry
          for (int i = at; i + 1 < entries_used; i++) begin
            entry_keys[i] = entry_keys[i+1];
            entry_vals[i] = entry_vals[i+1];
          end
          entries_used--;
          r.found    = 1'b1;
          r.position = POS_W'(at);
        end
      end
      OP_LOOKUP: begin
        at = locate(k);
        if (at < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found    = 1'b1;
          r.position = POS_W'(at);
          r.value    = entry_vals[at];
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(entries_used);
    return r;
  endfunction

  task automatic check_field(string name, logic [STR_W-1:0] exp_v, logic [STR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      bad++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // compare results first, then queue the response of a newly taken item
  always @(posedge clk) begin
    if (rst) begin
      entries_used = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          bad++;
          $display("%0t: result with none expected, tuser %0h tdata %0h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = owed_q.pop_front();
          check_field("status", STR_W'(want.status),
                      STR_W'(m_axis_tuser[STATUS_W-1:0]));
          check_field("found", STR_W'(want.found), STR_W'(m_axis_tuser[STATUS_W]));
          check_field("position", STR_W'(want.position),
                      STR_W'(m_axis_tdata[POS_W-1:0]));
          check_field("value_out_lo", STR_W'(want.value[63:0]),
                      STR_W'(m_axis_tdata[POS_W +: WORD_W]));
          check_field("value_out_mid", STR_W'(want.value[127:64]),
                      STR_W'(m_axis_tdata[POS_W+WORD_W +: WORD_W]));
          check_field("value_out_hi", STR_W'(want.value[STR_W-1:128]),
                      STR_W'(m_axis_tdata[POS_W+2*WORD_W +: HI_W]));
          check_field("count", STR_W'(want.count),
                      STR_W'(m_axis_tdata[POS_W+STR_W +: COUNT_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_q.push_back(apply_item(op_t'(s_axis_tuser), s_axis_tdata));
      end
    end
    mismatches     <= bad;
    responses_owed <= owed_q.size();
  end

endmodule

// ===== tb/sv/key_value_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_tb
// Drives set, remove and lookup items into the key/value table: a directed
// opening over the string end, update, append, shift and missing key cases,
// then random phases over small and large key pools that fill the table,
// drain it and mix noise in. Both sides idle in random bursts and the
// receiver holds off once for a long stretch. The checker does the compare.
// ----------------------------------------------------------------------------

module key_value_table_tb;
  import kvt_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int POOL_MAX     = 128;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  int mismatches;
  int responses_owed;
  int cycles = 0;
  bit calm = 1'b0;
  bit squeeze = 1'b0;
  bit squeeze_done = 1'b0;

  logic [STR_W-1:0] key_pool [POOL_MAX];
  int               pool_size = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_value_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  kv_table_checker table_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatches     (mismatches),
    .responses_owed (responses_owed)
  );

  // watchdog
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls, one long hold-off, none in the calm tail
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze && !squeeze_done) begin
        squeeze_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // string of random length with nonzero bytes
  function automatic logic [STR_W-1:0] rand_str();
    logic [STR_W-1:0] s;
    int               len;
    int               pick;
    s    = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      len = 0;
    end else if (pick <= 3) begin
      len = STR_BYTES;
    end else begin
      len = $urandom_range(1, STR_BYTES - 1);
    end
    for (int i = 0; i < len; i++) begin
      s[i*8 +: 8] = 8'($urandom_range(1, 255));
    end
    return s;
  endfunction

  function automatic logic [STR_W-1:0] rand_bits();
    logic [159:0] w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return w[STR_W-1:0];
  endfunction

  // half the time, fill the bytes after the terminator with junk
  function automatic logic [STR_W-1:0] garble(logic [STR_W-1:0] s);
    bit ended;
    bit junk;
    ended = 1'b0;
    junk  = 1'($urandom_range(0, 1));
    for (int i = 0; i < STR_BYTES; i++) begin
      if (ended && junk) begin
        s[i*8 +: 8] = 8'($urandom_range(0, 255));
      end else if (s[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return s;
  endfunction

  // offer one item, with an occasional idle burst first
  task automatic send_item(op_t op, logic [STR_W-1:0] key, logic [STR_W-1:0] val);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, key};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic fill_pool(int n);
    pool_size = n;
    for (int i = 0; i < n; i++) begin
      key_pool[i] = rand_str();
    end
  endtask

  // weighted op mix over the key pool; the remainder is raw noise
  task automatic random_item(int set_w, int rem_w, int look_w);
    logic [STR_W-1:0] key;
    logic [STR_W-1:0] val;
    int               r;
    r   = $urandom_range(0, 99);
    key = garble(key_pool[$urandom_range(0, pool_size - 1)]);
    val = garble(rand_str());
    if (r < set_w) begin
      send_item(OP_SET, key, val);
    end else if (r < set_w + rem_w) begin
      send_item(OP_REMOVE, key, val);
    end else if (r < set_w + rem_w + look_w) begin
      send_item(OP_LOOKUP, key, val);
    end else begin
      send_item(op_t'($urandom_range(0, 3)), rand_bits(), rand_bits());
    end
  endtask

  initial begin
    logic [STR_W-1:0] ka;
    logic [STR_W-1:0] kb;
    logic [STR_W-1:0] kc;
    logic [STR_W-1:0] kb_alt;
    logic [STR_W-1:0] empty_alt;
    ka = '1;
    kb = STR_W'(24'h636261);
    kc = STR_W'(88'h0A0B0C0D0E0F1011121314);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // missing key on an empty table, unused opcode
    send_item(OP_LOOKUP, ka, rand_bits());
    send_item(OP_REMOVE, ka, rand_bits());
    send_item(OP_NONE, rand_bits(), rand_bits());

    // appends: full-length key, empty key, short key with junk past its end
    send_item(OP_SET, ka, '1);
    send_item(OP_SET, '0, '0);
    kb_alt = rand_bits();
    kb_alt[23:0]  = kb[23:0];
    kb_alt[31:24] = 8'h00;
    send_item(OP_SET, kb_alt, garble(rand_str()));

    // junk past the end must not break the match
    kb_alt = rand_bits();
    kb_alt[23:0]  = kb[23:0];
    kb_alt[31:24] = 8'h00;
    send_item(OP_LOOKUP, kb_alt, rand_bits());
    send_item(OP_SET, kb, garble(rand_str()));
    send_item(OP_LOOKUP, ka, '0);
    empty_alt = rand_bits();
    empty_alt[7:0] = 8'h00;
    send_item(OP_LOOKUP, empty_alt, '0);

    // remove in the middle shifts later entries down
    send_item(OP_SET, kc, rand_str());
    send_item(OP_REMOVE, kb, '0);
    send_item(OP_LOOKUP, kc, '0);
    send_item(OP_REMOVE, ka, '0);
    send_item(OP_REMOVE, ka, '0);
    send_item(OP_LOOKUP, kb, '0);
    send_item(OP_NONE, '1, '1);
    send_item(OP_REMOVE, kc, '0);
    send_item(OP_REMOVE, empty_alt, '0);
    send_item(OP_LOOKUP, '0, '0);

    // small pool, mixed ops
    fill_pool(8);
    repeat (200) random_item(40, 30, 25);

    // large pool, set heavy: fills the table; receiver holds off meanwhile
    fill_pool(100);
    squeeze = 1'b1;
    repeat (250) random_item(75, 10, 13);

    // drain
    repeat (200) random_item(15, 60, 23);

    // medium pool, then the tail with no idling
    fill_pool(20);
    repeat (100) random_item(40, 25, 30);
    calm = 1'b1;
    repeat (100) random_item(40, 25, 30);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (responses_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && responses_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
